[rtl/core/trb_pkg.sv]
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types and codes for the topic ring buffer with aging.
// ----------------------------------------------------------------------------
package trb_pkg;

    typedef enum logic [1:0] {
        OP_PUBLISH = 2'd0,
        OP_READ    = 2'd1,
        OP_RETIRE  = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_DONE = 2'd1,
        ST_JUMP = 2'd2
    } t_status;

    localparam logic REG_TOPICS_IN_USE = 1'b0;
    localparam logic REG_AGE_LIMIT     = 1'b1;

    typedef struct packed {
        t_opcode     op;
        logic        active;
        logic [3:0]  topic;
        logic [31:0] last_seen;
        logic [15:0] publisher_id;
        logic [31:0] payload;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [31:0] seq;
        logic [15:0] publisher;
        logic [31:0] payload;
        logic [31:0] stamp;
    } t_result;

endpackage

[rtl/core/topic_ring_buffer_with_aging.sv]
// ----------------------------------------------------------------------------
// topic_ring_buffer_with_aging
// Several circular topic queues with a global sequence counter and aging.
// ----------------------------------------------------------------------------
// operation: the back end takes one item at a time and waits for its result to be
//   popped; a read scans up to CAPACITY slots through the registered slot memory port
// reset: synchronous active low; queues empty, sequence counter 1, registers at
//   defaults; slot memory is not cleared
module topic_ring_buffer_with_aging #(
    parameter int TOPICS   = 4,
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_topic,
    input  logic [31:0] i_last_seen,
    input  logic [15:0] i_publisher_id,
    input  logic [31:0] i_payload,
    input  logic [31:0] i_now,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_entry_seq,
    output logic [15:0] o_entry_publisher,
    output logic [31:0] o_entry_payload,
    output logic [31:0] o_entry_stamp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import trb_pkg::*;

    logic [2:0]  r_topics_in_use;
    logic [31:0] r_age_limit;
    logic        w_cmd_valid, w_cmd_take, w_res_valid;
    t_cmd        w_cmd;
    t_result     w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topics_in_use <= 3'd3;
            r_age_limit     <= 32'd1000000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TOPICS_IN_USE) begin
                r_topics_in_use <= i_cfg_data[2:0];
            end else begin
                r_age_limit <= i_cfg_data;
            end
        end
    end

    trb_front #(.TOPICS(TOPICS)) u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_opcode, .i_topic, .i_last_seen, .i_publisher_id, .i_payload, .i_now,
        .i_topics_in_use(r_topics_in_use),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    trb_back #(.TOPICS(TOPICS), .CAPACITY(CAPACITY)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .i_age_limit(r_age_limit),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_take(pop)
    );

    assign empty             = !w_res_valid;
    assign o_status          = w_res.status;
    assign o_entry_seq       = w_res.seq;
    assign o_entry_publisher = w_res.publisher;
    assign o_entry_payload   = w_res.payload;
    assign o_entry_stamp     = w_res.stamp;

endmodule

[rtl/core/trb_front.sv]
// ----------------------------------------------------------------------------
// trb_front
// Accepts items, checks the topic against the active count and queues a
// classified command for the back end in a short fifo.
// ----------------------------------------------------------------------------
module trb_front #(
    parameter int TOPICS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_opcode,
    input  logic [1:0]          i_topic,
    input  logic [31:0]         i_last_seen,
    input  logic [15:0]         i_publisher_id,
    input  logic [31:0]         i_payload,
    input  logic [31:0]         i_now,
    input  logic [2:0]          i_topics_in_use,
    output logic                o_cmd_valid,
    output trb_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_take
);
    import trb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic [4:0] w_lim;
    logic       w_push_ok;
    t_cmd       w_cmd;

    always_comb begin
        w_lim = ({2'b0, i_topics_in_use} > 5'(TOPICS)) ? 5'(TOPICS)
                                                       : {2'b0, i_topics_in_use};
        w_cmd.op           = t_opcode'(i_opcode);
        w_cmd.active       = ({3'b0, i_topic} < w_lim);
        w_cmd.topic        = {2'b0, i_topic};
        w_cmd.last_seen    = i_last_seen;
        w_cmd.publisher_id = i_publisher_id;
        w_cmd.payload      = i_payload;
        w_cmd.now          = i_now;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign w_push_ok   = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr ^ w_push_ok;
        n_rd  = r_rd ^ (i_cmd_take && o_cmd_valid);
        n_cnt = r_cnt + 2'(w_push_ok) - 2'(i_cmd_take && o_cmd_valid);
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/core/trb_back.sv]
// ----------------------------------------------------------------------------
// trb_back
// Executes publish, read scan and retire against the slot memory and holds
// the finished transaction in a result register.
// ----------------------------------------------------------------------------
module trb_back #(
    parameter int TOPICS   = 4,
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  trb_pkg::t_cmd       i_cmd,
    output logic                o_cmd_take,
    input  logic [31:0]         i_age_limit,
    output logic                o_res_valid,
    output trb_pkg::t_result    o_res,
    input  logic                i_res_take
);
    import trb_pkg::*;

    localparam int TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
    localparam int CW = $clog2(CAPACITY);
    localparam int AW = TW + CW;
    localparam int DEPTH = TOPICS * (1 << CW);
    localparam int SLW = 32 + 32 + 16 + 32;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_HOLD} t_state;

    // slot position wrap; the head is below CAPACITY and the offset is at most CAPACITY
    function automatic logic [CW-1:0] f_wrap(logic [CW:0] sum);
        return (sum >= (CW+1)'(CAPACITY)) ? CW'(sum - (CW+1)'(CAPACITY)) : sum[CW-1:0];
    endfunction

    logic [SLW-1:0] r_mem [DEPTH];
    logic [SLW-1:0] r_rdata;
    logic [CW-1:0]  r_head [TOPICS];
    logic [CW:0]    r_live [TOPICS];
    logic [31:0]    r_next_seq;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [CW:0] r_k;
    t_result     r_res;
    logic        r_res_valid;

    logic [TW-1:0] w_t;
    logic [CW-1:0] w_head_t;
    logic [CW:0]   w_live_t;
    logic [AW-1:0] w_addr, w_waddr;
    logic [31:0]   w_seq, w_stamp, w_payload;
    logic [15:0]   w_pub;
    logic          w_start;

    assign w_t      = r_cmd.topic[TW-1:0];
    assign w_head_t = r_head[w_t];
    assign w_live_t = r_live[w_t];
    assign w_addr   = {w_t, f_wrap({1'b0, w_head_t} + r_k)};
    assign w_waddr  = {i_cmd.topic[TW-1:0],
                       f_wrap({1'b0, r_head[i_cmd.topic[TW-1:0]]}
                              + r_live[i_cmd.topic[TW-1:0]])};
    assign {w_seq, w_stamp, w_pub, w_payload} = r_rdata;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign w_start     = (r_state == S_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_cmd_take  = w_start;

    // publish writes at accept time, reads go through the registered port
    always_ff @(posedge i_clk) begin
        if (w_start && i_cmd.op == OP_PUBLISH && i_cmd.active
            && r_live[i_cmd.topic[TW-1:0]] < (CW+1)'(CAPACITY) && r_next_seq != 32'hFFFF_FFFF) begin
            r_mem[w_waddr] <= {r_next_seq, i_cmd.now, i_cmd.publisher_id, i_cmd.payload};
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_next_seq  <= 32'd1;
            r_k         <= '0;
            for (int i = 0; i < TOPICS; i++) begin
                r_head[i] <= '0;
                r_live[i] <= '0;
            end
        end else begin
            if (r_res_valid && i_res_take) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        if (!i_cmd.active || i_cmd.op == OP_NOP) begin
                            r_res       <= '{ST_NONE, 32'd0, 16'd0, 32'd0, 32'd0};
                            r_res_valid <= 1'b1;
                        end else if (i_cmd.op == OP_PUBLISH) begin
                            r_res_valid <= 1'b1;
                            if (r_live[i_cmd.topic[TW-1:0]] < (CW+1)'(CAPACITY)
                                && r_next_seq != 32'hFFFF_FFFF) begin
                                r_live[i_cmd.topic[TW-1:0]] <=
                                    r_live[i_cmd.topic[TW-1:0]] + (CW+1)'(1);
                                r_next_seq <= r_next_seq + 32'd1;
                                r_res <= '{ST_DONE, r_next_seq, 16'd0, 32'd0, i_cmd.now};
                            end else begin
                                r_res <= '{ST_NONE, 32'd0, 16'd0, 32'd0, 32'd0};
                            end
                        end else begin
                            r_res   <= '{ST_NONE, 32'd0, 16'd0, 32'd0, 32'd0};
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    // address is presented this cycle, data lands next
                    if (r_k >= w_live_t) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_HOLD;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_cmd.op == OP_RETIRE) begin
                        if ((r_cmd.now - w_stamp) >= i_age_limit) begin
                            r_head[w_t] <= f_wrap({1'b0, w_head_t} + (CW+1)'(1));
                            r_live[w_t] <= w_live_t - (CW+1)'(1);
                            r_res <= '{ST_DONE, 32'd0, 16'd0, 32'd0, 32'd0};
                        end
                        r_res_valid <= 1'b1;
                        r_state     <= S_HOLD;
                    end else if (w_seq > r_cmd.last_seen) begin
                        r_res <= '{((w_seq == r_cmd.last_seen + 32'd1) ? ST_DONE : ST_JUMP),
                                   w_seq, w_pub, w_payload, w_stamp};
                        r_res_valid <= 1'b1;
                        r_state     <= S_HOLD;
                    end else begin
                        r_k     <= r_k + (CW+1)'(1);
                        r_state <= S_RD;
                    end
                end
                S_HOLD: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
